// ===== rtl/core/bba_pkg.sv =====
// Shared constants of the block bitmap allocator.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int unsigned MAP_BYTES = 4096;
  localparam int unsigned MAP_BITS  = MAP_BYTES * 8;

  // Bitmap storage: 32-bit words, one read and one write port.
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OFS_W     = 5;
  localparam int unsigned NUM_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned POS_W     = ADDR_W + OFS_W;
  // Width for block numbers, limits and region bounds.
  localparam int unsigned NUM_W     = (POS_W + 1 > 17) ? POS_W + 1 : 17;

  localparam int unsigned REG_W     = 16;
  localparam int unsigned IDX_W     = 15;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'd1;

  localparam logic [REG_W-1:0] DATA_START_RST   = 16'd0;
  localparam logic [REG_W-1:0] TOTAL_BLOCKS_RST = 16'd32768;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 2'd3;

endpackage

// ===== rtl/core/block_bitmap_allocator_top.sv =====
// First-fit block bitmap allocator with the bitmap held in a word-wide RAM.
// Free: the RAM read (S_FREE_RD, S_FREE_CHK), then the write-back (S_WRITE) and S_RESP.
// Allocate: a scan of the bitmap words (32 blocks per word, one word a cycle through
// the RAM read port), then S_WRITE and S_RESP; a full region goes straight to S_RESP.
// One request at a time; the next is taken while the result beat waits at the output.
// After reset a clearing pass writes all NUM_WORDS words before the first request is
// taken; configuration writes are taken during it.
`timescale 1ns / 1ps

module block_bitmap_allocator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bba_pkg::REG_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [14:0] block_index, [15] zero
  input  logic [bba_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] status, [16:2] granted_block, [32:17] free_count, [39:33] zero
  output logic [bba_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import bba_pkg::*;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_FREE_RD  = 3'd3;
  localparam logic [2:0] S_FREE_CHK = 3'd4;
  localparam logic [2:0] S_WRITE    = 3'd5;
  localparam logic [2:0] S_RESP     = 3'd6;

  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [WORD_W-1:0] rdata_q;

  logic [2:0]          state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [ADDR_W-1:0]   rd_addr_q, rd_addr_d;
  logic [ADDR_W-1:0]   chk_addr_q, chk_addr_d;
  logic                chk_vld_q, chk_vld_d;
  logic                free_q, free_d;
  logic [WORD_W-1:0]   word_q, word_d;
  logic [WORD_W-1:0]   onehot_q, onehot_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]    granted_q, granted_d;
  logic [REG_W-1:0]    used_q, used_d;
  logic [REG_W-1:0]    ds_q, tb_q;
  logic                out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;

  logic [NUM_W-1:0]    tb_ext, ds_ext, lim, idx_ext, lim_m1;
  logic                region_ok;
  logic [REG_W-1:0]    region, free_cnt;
  logic [ADDR_W-1:0]   ds_word, last_word;
  logic [WORD_W-1:0]   lo_mask, hi_mask, avail, lowest;
  logic [OFS_W-1:0]    pos;
  logic [POS_W-1:0]    grant_full;
  logic                in_acc;

  // Region bounds and free count.
  always_comb begin
    tb_ext    = NUM_W'(tb_q);
    ds_ext    = NUM_W'(ds_q);
    lim       = (tb_ext < NUM_W'(MAP_BITS)) ? tb_ext : NUM_W'(MAP_BITS);
    lim_m1    = lim - NUM_W'(1);
    region_ok = lim > ds_ext;
    region    = region_ok ? REG_W'(lim - ds_ext) : '0;
    free_cnt  = (region > used_q) ? region - used_q : '0;
    ds_word   = ds_ext[OFS_W +: ADDR_W];
    last_word = lim_m1[OFS_W +: ADDR_W];
    idx_ext   = NUM_W'(s_axis_tdata[IDX_W-1:0]);
  end

  // Lowest clear bit inside the region of the word under test.
  always_comb begin
    lo_mask = (chk_addr_q == ds_word) ? ({WORD_W{1'b1}} << ds_q[OFS_W-1:0])
                                      : {WORD_W{1'b1}};
    hi_mask = ((chk_addr_q == last_word) && (lim[OFS_W-1:0] != '0))
              ? ~({WORD_W{1'b1}} << lim[OFS_W-1:0]) : {WORD_W{1'b1}};
    avail   = ~rdata_q & lo_mask & hi_mask;
    lowest  = avail & (~avail + WORD_W'(1));
    pos     = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (lowest[j]) pos = pos | OFS_W'(j);
    end
    grant_full = {chk_addr_q, pos};
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    rd_addr_d  = rd_addr_q;
    chk_addr_d = chk_addr_q;
    chk_vld_d  = chk_vld_q;
    free_d     = free_q;
    word_d     = word_q;
    onehot_d   = onehot_q;
    status_d   = status_q;
    granted_d  = granted_q;
    used_d     = used_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    mem_we     = 1'b0;
    mem_waddr  = chk_addr_q;
    mem_wdata  = free_q ? (word_q & ~onehot_q) : (word_q | onehot_q);

    if (out_vld_q && m_axis_tready) out_vld_d = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(NUM_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          free_d    = (s_axis_tuser == MODE_FREE);
          granted_d = '0;
          status_d  = STS_OK;
          chk_vld_d = 1'b0;
          onehot_d  = WORD_W'(1) << s_axis_tdata[OFS_W-1:0];
          if (s_axis_tuser == MODE_ALLOC) begin
            rd_addr_d = ds_word;
            if (free_cnt == '0) begin
              status_d = STS_NO_FREE;
              state_d  = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            rd_addr_d = idx_ext[OFS_W +: ADDR_W];
            if (idx_ext < ds_ext || idx_ext >= lim) begin
              status_d = STS_RANGE;
              state_d  = S_RESP;
            end else begin
              state_d = S_FREE_RD;
            end
          end
        end
      end
      S_SCAN: begin
        // one word read issued per cycle, tested in the next cycle
        chk_addr_d = rd_addr_q;
        rd_addr_d  = rd_addr_q + ADDR_W'(1);
        chk_vld_d  = 1'b1;
        if (chk_vld_q) begin
          if (avail != '0) begin
            word_d     = rdata_q;
            onehot_d   = lowest;
            chk_addr_d = chk_addr_q;
            granted_d  = grant_full[IDX_W-1:0];
            state_d    = S_WRITE;
          end else if (chk_addr_q == last_word) begin
            status_d = STS_NO_FREE;
            state_d  = S_RESP;
          end
        end
      end
      S_FREE_RD: begin
        chk_addr_d = rd_addr_q;
        state_d    = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        word_d = rdata_q;
        if ((rdata_q & onehot_q) == '0) begin
          status_d = STS_NOT_ALLOC;
          state_d  = S_RESP;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we = 1'b1;
        if (free_q) begin
          if (used_q != '0) used_d = used_q - REG_W'(1);
        end else begin
          if (used_q != '1) used_d = used_q + REG_W'(1);
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = {7'd0, free_cnt, granted_q, status_q};
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      chk_vld_q <= 1'b0;
      used_q    <= '0;
      out_vld_q <= 1'b0;
      ds_q      <= DATA_START_RST;
      tb_q      <= TOTAL_BLOCKS_RST;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      chk_vld_q <= chk_vld_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DATA_START:   ds_q <= cfg_data_i;
          CFG_TOTAL_BLOCKS: tb_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    chk_addr_q <= chk_addr_d;
    free_q     <= free_d;
    word_q     <= word_d;
    onehot_q   <= onehot_d;
    status_q   <= status_d;
    granted_q  <= granted_d;
    out_data_q <= out_data_d;
  end

  // Bitmap RAM: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[rd_addr_q];
  end

  a_write_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> $onehot(onehot_q))
    else $error("write-back does not touch exactly one bit");

  a_write_bit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (((word_q & onehot_q) != '0) == free_q))
    else $error("allocated a set bit or freed a clear bit");

  a_count_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_WRITE) |=> $stable(used_q))
    else $error("used count changed outside write-back");

  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_data_q[1:0] != STS_OK)) |-> (out_data_q[16:2] == '0))
    else $error("granted block set on failed request");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q == S_CLEAR) && (state_q == S_IDLE) |-> (clr_q == '0))
    else $error("clearing pass ended early");

endmodule

// ===== test/block_bitmap_allocator_top_tb.sv =====
// Self-checking testbench for the block bitmap allocator top level.
`timescale 1ns / 1ps

module block_bitmap_allocator_top_tb;
  import bba_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] block_index;
  } alloc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_block;
    logic [REG_W-1:0]    free_count;
  } alloc_resp_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [REG_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow of the allocator state
  bit          block_used [MAP_BITS];
  int unsigned used_blocks = 0;
  int unsigned start_reg   = 32'(DATA_START_RST);
  int unsigned total_reg   = 32'(TOTAL_BLOCKS_RST);
  int unsigned held_blocks [$];

  alloc_req_t  request_queue [$];
  alloc_resp_t pending_responses [$];

  int          mismatches     = 0;
  int          requests_sent  = 0;
  int          responses_seen = 0;
  int          settings_used  = 0;
  int          status_hits [4];
  int unsigned quiet_cycles   = 0;
  logic        req_taken      = 1'b0;

  int          in_gap        = 0;
  int          out_gap       = 0;
  int          hold_left     = 0;
  int          in_idle_pct   = 10;
  int          out_idle_pct  = 10;
  bit          quiet         = 1'b0;
  bit          pressure_done = 1'b0;

  always #10 clk_i = ~clk_i;

  block_bitmap_allocator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic int unsigned alloc_limit();
    return (total_reg < MAP_BITS) ? total_reg : MAP_BITS;
  endfunction

  function automatic int unsigned blocks_available();
    int unsigned lim;
    int unsigned region;
    lim = alloc_limit();
    region = (lim > start_reg) ? lim - start_reg : 0;
    return (region > used_blocks) ? region - used_blocks : 0;
  endfunction

  // First-fit allocate or free against the shadow bitmap; returns the response
  function automatic alloc_resp_t allocate_or_free(alloc_req_t req);
    alloc_resp_t resp;
    int unsigned lim;
    int unsigned b;
    int unsigned idx;
    int          pos;
    bit          found;
    lim = alloc_limit();
    idx = 32'(req.block_index);
    resp.status = STS_OK;
    resp.granted_block = '0;
    found = 1'b0;
    pos = -1;
    if (req.mode == MODE_ALLOC) begin
      if (blocks_available() == 0) begin
        resp.status = STS_NO_FREE;
      end else begin
        for (b = start_reg; b < lim; b++) begin
          if (!block_used[b]) begin
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          resp.status = STS_NO_FREE;
        end else begin
          block_used[b] = 1'b1;
          if (used_blocks < 16'hFFFF) used_blocks++;
          resp.granted_block = b[IDX_W-1:0];
          held_blocks.push_back(b);
        end
      end
    end else begin
      if (idx < start_reg || idx >= lim) begin
        resp.status = STS_RANGE;
      end else if (!block_used[idx]) begin
        resp.status = STS_NOT_ALLOC;
      end else begin
        block_used[idx] = 1'b0;
        if (used_blocks > 0) used_blocks--;
        foreach (held_blocks[k]) if (held_blocks[k] == idx) pos = k;
        if (pos >= 0) held_blocks.delete(pos);
      end
    end
    resp.free_count = REG_W'(blocks_available());
    return resp;
  endfunction

  // Monitor: register writes, result checks, request prediction, watchdog
  always @(posedge clk_i) begin : monitor
    alloc_resp_t want;
    alloc_resp_t got;
    alloc_req_t  req;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DATA_START:   start_reg = 32'(cfg_data_i);
          CFG_TOTAL_BLOCKS: total_reg = 32'(cfg_data_i);
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status        = m_axis_tdata[1:0];
        got.granted_block = m_axis_tdata[16:2];
        got.free_count    = m_axis_tdata[32:17];
        responses_seen++;
        if (pending_responses.size() == 0) begin
          $error("result beat with no request outstanding: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_responses.pop_front();
          status_hits[want.status]++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.granted_block !== want.granted_block) begin
            $error("granted_block: expected %0d, got %0d",
                   want.granted_block, got.granted_block);
            mismatches++;
          end
          if (got.free_count !== want.free_count) begin
            $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.mode        = s_axis_tuser;
        req.block_index = s_axis_tdata[IDX_W-1:0];
        pending_responses.push_back(allocate_or_free(req));
        requests_sent++;
      end
      req_taken <= s_axis_tvalid && s_axis_tready;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Driver: request beats on the slave side, readiness on the master side
  always @(negedge clk_i) begin : driver
    alloc_req_t req;
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && hold_left == 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 15);
          s_axis_tvalid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          req = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_DATA_W'(req.block_index);
          s_axis_tuser  <= req.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end

      // one long hold-off so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!pressure_done && responses_seen >= HOLD_AFTER) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_request(input logic mode, input int unsigned idx);
    alloc_req_t req;
    req.mode = mode;
    req.block_index = idx[IDX_W-1:0];
    @(posedge clk_i);
    #1;
    while (request_queue.size() >= QUEUE_DEPTH) begin
      @(posedge clk_i);
      #1;
    end
    request_queue.push_back(req);
  endtask

  task automatic drain();
    @(posedge clk_i);
    #1;
    while (request_queue.size() != 0 || s_axis_tvalid || pending_responses.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[REG_W-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Region changes only with the block idle
  task automatic set_region(input int unsigned ds, input int unsigned tb);
    drain();
    write_reg(CFG_DATA_START, ds);
    write_reg(CFG_TOTAL_BLOCKS, tb);
    settings_used++;
  endtask

  task automatic random_phase(input int count, input int unsigned ds, input int unsigned tb);
    int unsigned lim;
    int unsigned idx;
    int unsigned pick;
    int unsigned in_region [$];
    set_region(ds, tb);
    lim = (tb < MAP_BITS) ? tb : MAP_BITS;
    repeat (count) begin
      if ($urandom_range(0, 99) < 55) begin
        push_request(MODE_ALLOC, $urandom_range(0, (1 << IDX_W) - 1));
      end else begin
        pick = $urandom_range(0, 99);
        in_region.delete();
        foreach (held_blocks[k])
          if (held_blocks[k] >= ds && held_blocks[k] < lim) in_region.push_back(held_blocks[k]);
        if (pick < 60 && in_region.size() > 0)
          idx = in_region[$urandom_range(0, in_region.size() - 1)];
        else if (pick < 85 && lim > ds)
          idx = $urandom_range(ds, lim - 1);
        else
          idx = $urandom_range(0, (1 << IDX_W) - 1);
        push_request(MODE_FREE, idx);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned ds;
    int unsigned tb;
    int unsigned span;
    foreach (status_hits[i]) status_hits[i] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: whole map
    push_request(MODE_ALLOC, 0);
    push_request(MODE_ALLOC, 16'h7FFF);
    push_request(MODE_FREE, 0);
    push_request(MODE_FREE, 0);
    push_request(MODE_ALLOC, 0);
    push_request(MODE_FREE, 32767);

    // single block at the top, limit saturated to the map size
    set_region(32767, 65535);
    push_request(MODE_ALLOC, 0);
    push_request(MODE_ALLOC, 0);
    push_request(MODE_FREE, 32766);
    push_request(MODE_FREE, 32767);

    // small region: fill it, overflow it, bounds on both sides, double free
    set_region(100, 104);
    repeat (5) push_request(MODE_ALLOC, 0);
    push_request(MODE_FREE, 99);
    push_request(MODE_FREE, 104);
    push_request(MODE_FREE, 102);
    push_request(MODE_FREE, 102);
    push_request(MODE_ALLOC, 0);

    // empty regions
    set_region(0, 0);
    push_request(MODE_ALLOC, 0);
    push_request(MODE_FREE, 0);
    set_region(65535, 65535);
    push_request(MODE_ALLOC, 0);
    push_request(MODE_FREE, 5);

    for (int p = 0; p < 8; p++) begin
      drain();
      if (p % 3 == 0) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = $urandom_range(5, 30);
        out_idle_pct = $urandom_range(5, 30);
      end
      span = $urandom_range(1, 48);
      case (p)
        0: begin ds = 0; tb = 65535; end
        6: begin ds = $urandom_range(0, 65535); tb = $urandom_range(0, 65535); end
        7: begin
          quiet = 1'b1;
          ds = MAP_BITS - span;
          tb = MAP_BITS;
        end
        default: begin
          ds = $urandom_range(0, MAP_BITS - span);
          tb = ds + span;
        end
      endcase
      random_phase(116, ds, tb);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("checked %0d results for %0d requests over %0d region settings",
             responses_seen, requests_sent, settings_used + 1);
    $display("ok %0d, no free block %0d, out of range %0d, not allocated %0d",
             status_hits[STS_OK], status_hits[STS_NO_FREE], status_hits[STS_RANGE],
             status_hits[STS_NOT_ALLOC]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
